### design/chained_hash_flow_table_top_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the chained hash flow table
// Clocked on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef CHAINED_HASH_FLOW_TABLE_TOP_MACROS_SVH
`define CHAINED_HASH_FLOW_TABLE_TOP_MACROS_SVH

// same-cycle implication
`define CHFT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define CHFT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### design/chft_pkg.sv
// ----------------------------------------------------------------------------
// chft_pkg
// Types and codes shared by the chained hash flow table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package chft_pkg;

  localparam int unsigned NUM_BUCKETS_DEF = 256;
  localparam int unsigned MAX_ENTRIES_DEF = 1024;

  localparam int unsigned CMD_W    = 2;
  localparam int unsigned KEY_W    = 32;
  localparam int unsigned TIME_W   = 64;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned INDEX_W  = 10;
  localparam int unsigned BCOUNT_W = 9;

  localparam logic [BCOUNT_W-1:0] BCOUNT_RESET = 9'd256;

  localparam logic [CMD_W-1:0] CMD_ADD  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_FIND = 2'd1;
  localparam logic [CMD_W-1:0] CMD_DEL  = 2'd2;

  localparam logic [STATUS_W-1:0] ST_FOUND    = 3'd0;
  localparam logic [STATUS_W-1:0] ST_INSERTED = 3'd1;
  localparam logic [STATUS_W-1:0] ST_MISSING  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_DELETED  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_FULL     = 3'd4;

  typedef struct packed {
    logic [CMD_W-1:0]  command;
    logic [KEY_W-1:0]  flow_key;
    logic [TIME_W-1:0] packet_time;
  } chft_req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [INDEX_W-1:0]  entry_index;
    logic [TIME_W-1:0]   last_time;
  } chft_rsp_t;

endpackage
`default_nettype wire

### design/chft_ram.sv
// ----------------------------------------------------------------------------
// chft_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module chft_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

### design/chained_hash_flow_table_top.sv
// ----------------------------------------------------------------------------
// chained_hash_flow_table_top
// Flow table keyed by a 32-bit address, with chained buckets and a free stack.
// ----------------------------------------------------------------------------
// channel | ports                          | direction
// in      | in_valid, in_ready, in_data    | request in
// out     | out_valid, out_ready, out_data | result out
// cfg     | cfg_wr_en, cfg_wr_data         | bucket count write
//
// After a request is taken: a bit-serial key modulo, a head read, a compare per
// chain entry, a check when the walk runs off the chain end, a free-stack pop
// on an insert, and a commit; then the block returns to idle.
// in_ready is high only in idle. The commit stalls while the previous result
// still waits in the output register; no new request is taken meanwhile.
// Reset empties all buckets and refills the free stack at once (no sweep).
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "chained_hash_flow_table_top_macros.svh"
module chained_hash_flow_table_top #(
  parameter int unsigned NUM_BUCKETS = chft_pkg::NUM_BUCKETS_DEF,
  parameter int unsigned MAX_ENTRIES = chft_pkg::MAX_ENTRIES_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire chft_pkg::chft_req_t           in_data,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output chft_pkg::chft_rsp_t                out_data,
  input  wire logic                          cfg_wr_en,
  input  wire logic [chft_pkg::BCOUNT_W-1:0] cfg_wr_data
);
  import chft_pkg::*;

  localparam int unsigned IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int unsigned LW = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned BW = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
  localparam logic [LW-1:0] NIL = LW'(MAX_ENTRIES);
  localparam logic [IW-1:0] TOP_IDX = IW'(MAX_ENTRIES - 1);

  typedef enum logic [3:0] {
    S_IDLE, S_DIV, S_HEAD_WAIT, S_HEAD_GET, S_WALK, S_WALK_CHK,
    S_FREE_WAIT, S_FREE_GET, S_COMMIT
  } state_t;

  state_t              state_r, state_nxt;
  logic [BCOUNT_W-1:0] bc_r, bc_nxt;
  chft_req_t           req_r, req_nxt;
  logic [BCOUNT_W-1:0] div_r, div_nxt;
  logic [BCOUNT_W-1:0] rem_r, rem_nxt;
  logic [KEY_W-1:0]    ksh_r, ksh_nxt;
  logic [4:0]          cnt_r, cnt_nxt;
  logic [BW-1:0]       bucket_r, bucket_nxt;
  logic [LW-1:0]       head_r, head_nxt;
  logic [LW-1:0]       p_r, p_nxt;
  logic [LW-1:0]       prev_r, prev_nxt;
  logic [LW-1:0]       steps_r, steps_nxt;
  logic                hit_r, hit_nxt;
  logic [LW-1:0]       link_e_r, link_e_nxt;
  logic [TIME_W-1:0]   ftime_r, ftime_nxt;
  logic [IW-1:0]       e_r, e_nxt;
  logic [LW-1:0]       total_r, total_nxt;
  logic [LW-1:0]       min_r, min_nxt;
  logic                out_valid_r, out_valid_nxt;
  chft_rsp_t           out_r, out_nxt;
  logic [NUM_BUCKETS-1:0] hv_r, hv_nxt;

  logic [KEY_W-1:0]  keys_q;
  logic [TIME_W-1:0] times_q;
  logic [LW-1:0]     links_q;
  logic [IW-1:0]     free_q;
  logic [LW-1:0]     heads_q;

  logic keys_we, times_we, links_we, heads_we, free_we;
  logic [IW-1:0] links_wa;
  logic [LW-1:0] links_wd, heads_wd;
  logic [IW-1:0] pop_pos;
  logic [BCOUNT_W:0] div_try;
  logic commit_en;

  assign pop_pos   = IW'(total_r - LW'(1));
  assign div_try   = {rem_r, ksh_r[KEY_W-1]};
  assign commit_en = !out_valid_r || out_ready;

  chft_ram #(.WIDTH(KEY_W), .DEPTH(MAX_ENTRIES)) u_keys (
    .clk(clk), .we(keys_we), .waddr(e_r), .wdata(req_r.flow_key),
    .raddr(p_r[IW-1:0]), .rdata(keys_q));

  chft_ram #(.WIDTH(TIME_W), .DEPTH(MAX_ENTRIES)) u_times (
    .clk(clk), .we(times_we), .waddr(e_r), .wdata(req_r.packet_time),
    .raddr(p_r[IW-1:0]), .rdata(times_q));

  chft_ram #(.WIDTH(LW), .DEPTH(MAX_ENTRIES)) u_links (
    .clk(clk), .we(links_we), .waddr(links_wa), .wdata(links_wd),
    .raddr(p_r[IW-1:0]), .rdata(links_q));

  chft_ram #(.WIDTH(IW), .DEPTH(MAX_ENTRIES)) u_free (
    .clk(clk), .we(free_we), .waddr(total_r[IW-1:0]), .wdata(e_r),
    .raddr(pop_pos), .rdata(free_q));

  chft_ram #(.WIDTH(LW), .DEPTH(NUM_BUCKETS)) u_heads (
    .clk(clk), .we(heads_we), .waddr(bucket_r), .wdata(heads_wd),
    .raddr(bucket_r), .rdata(heads_q));

  always_comb begin
    state_nxt     = state_r;
    bc_nxt        = cfg_wr_en ? cfg_wr_data : bc_r;
    req_nxt       = req_r;
    div_nxt       = div_r;
    rem_nxt       = rem_r;
    ksh_nxt       = ksh_r;
    cnt_nxt       = cnt_r;
    bucket_nxt    = bucket_r;
    head_nxt      = head_r;
    p_nxt         = p_r;
    prev_nxt      = prev_r;
    steps_nxt     = steps_r;
    hit_nxt       = hit_r;
    link_e_nxt    = link_e_r;
    ftime_nxt     = ftime_r;
    e_nxt         = e_r;
    total_nxt     = total_r;
    min_nxt       = min_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_nxt       = out_r;
    hv_nxt        = hv_r;
    keys_we       = 1'b0;
    times_we      = 1'b0;
    links_we      = 1'b0;
    heads_we      = 1'b0;
    free_we       = 1'b0;
    links_wa      = e_r;
    links_wd      = head_r;
    heads_wd      = link_e_r;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          req_nxt = in_data;
          ksh_nxt = in_data.flow_key;
          rem_nxt = '0;
          cnt_nxt = '0;
          if (bc_r == '0) begin
            div_nxt = BCOUNT_W'(1);
          end else if (32'(bc_r) > 32'(NUM_BUCKETS)) begin
            div_nxt = BCOUNT_W'(NUM_BUCKETS);
          end else begin
            div_nxt = bc_r;
          end
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        // restoring remainder, one key bit per cycle
        if (div_try >= {1'b0, div_r}) begin
          rem_nxt = BCOUNT_W'(div_try - {1'b0, div_r});
        end else begin
          rem_nxt = div_try[BCOUNT_W-1:0];
        end
        ksh_nxt = {ksh_r[KEY_W-2:0], 1'b0};
        cnt_nxt = cnt_r + 5'd1;
        if (cnt_r == 5'd31) begin
          bucket_nxt = BW'(rem_nxt);
          state_nxt  = S_HEAD_WAIT;
        end
      end
      S_HEAD_WAIT: begin
        state_nxt = S_HEAD_GET;
      end
      S_HEAD_GET: begin
        head_nxt  = hv_r[bucket_r] ? heads_q : NIL;
        p_nxt     = head_nxt;
        prev_nxt  = NIL;
        steps_nxt = '0;
        hit_nxt   = 1'b0;
        state_nxt = S_WALK;
      end
      S_WALK: begin
        if (p_r >= NIL || steps_r >= NIL) begin
          hit_nxt = 1'b0;
          if (req_r.command == CMD_ADD && total_r != '0) begin
            state_nxt = S_FREE_WAIT;
          end else begin
            state_nxt = S_COMMIT;
          end
        end else begin
          state_nxt = S_WALK_CHK;
        end
      end
      S_WALK_CHK: begin
        if (keys_q == req_r.flow_key) begin
          hit_nxt    = 1'b1;
          e_nxt      = p_r[IW-1:0];
          link_e_nxt = links_q;
          ftime_nxt  = times_q;
          state_nxt  = S_COMMIT;
        end else begin
          prev_nxt  = p_r;
          p_nxt     = links_q;
          steps_nxt = steps_r + LW'(1);
          state_nxt = S_WALK;
        end
      end
      S_FREE_WAIT: begin
        state_nxt = S_FREE_GET;
      end
      S_FREE_GET: begin
        // stack slots below the low-water mark are unwritten since reset, so their initial value is computed
        if (LW'(pop_pos) < min_r) begin
          e_nxt = TOP_IDX - pop_pos;
        end else begin
          e_nxt = free_q;
        end
        state_nxt = S_COMMIT;
      end
      S_COMMIT: begin
        if (commit_en) begin
          out_valid_nxt = 1'b1;
          out_nxt.status      = ST_MISSING;
          out_nxt.entry_index = '0;
          out_nxt.last_time   = '0;
          case (req_r.command)
            CMD_ADD: begin
              if (hit_r) begin
                times_we = 1'b1;
                out_nxt.status      = ST_FOUND;
                out_nxt.entry_index = INDEX_W'(e_r);
                out_nxt.last_time   = req_r.packet_time;
              end else if (total_r == '0) begin
                out_nxt.status = ST_FULL;
              end else begin
                keys_we  = 1'b1;
                times_we = 1'b1;
                links_we = 1'b1;
                links_wa = e_r;
                links_wd = head_r;
                heads_we = 1'b1;
                heads_wd = LW'(e_r);
                hv_nxt[bucket_r] = 1'b1;
                total_nxt = total_r - LW'(1);
                if (total_nxt < min_r) begin
                  min_nxt = total_nxt;
                end
                out_nxt.status      = ST_INSERTED;
                out_nxt.entry_index = INDEX_W'(e_r);
                out_nxt.last_time   = req_r.packet_time;
              end
            end
            CMD_FIND: begin
              if (hit_r) begin
                out_nxt.status      = ST_FOUND;
                out_nxt.entry_index = INDEX_W'(e_r);
                out_nxt.last_time   = ftime_r;
              end
            end
            CMD_DEL: begin
              if (hit_r) begin
                if (prev_r < NIL) begin
                  links_we = 1'b1;
                  links_wa = prev_r[IW-1:0];
                  links_wd = link_e_r;
                end else begin
                  heads_we = 1'b1;
                  heads_wd = link_e_r;
                  hv_nxt[bucket_r] = 1'b1;
                end
                if (total_r < NIL) begin
                  free_we   = 1'b1;
                  total_nxt = total_r + LW'(1);
                end
                out_nxt.status      = ST_DELETED;
                out_nxt.entry_index = INDEX_W'(e_r);
              end
            end
            default: begin
            end
          endcase
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      bc_r        <= BCOUNT_RESET;
      total_r     <= NIL;
      min_r       <= NIL;
      out_valid_r <= 1'b0;
      hv_r        <= '0;
    end else begin
      state_r     <= state_nxt;
      bc_r        <= bc_nxt;
      total_r     <= total_nxt;
      min_r       <= min_nxt;
      out_valid_r <= out_valid_nxt;
      hv_r        <= hv_nxt;
    end
    req_r    <= req_nxt;
    div_r    <= div_nxt;
    rem_r    <= rem_nxt;
    ksh_r    <= ksh_nxt;
    cnt_r    <= cnt_nxt;
    bucket_r <= bucket_nxt;
    head_r   <= head_nxt;
    p_r      <= p_nxt;
    prev_r   <= prev_nxt;
    steps_r  <= steps_nxt;
    hit_r    <= hit_nxt;
    link_e_r <= link_e_nxt;
    ftime_r  <= ftime_nxt;
    e_r      <= e_nxt;
    out_r    <= out_nxt;
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  `CHFT_ASSERT_NOW(a_total_bound, 1'b1, total_r <= NIL, "free count above table size")
  `CHFT_ASSERT_NOW(a_min_le_total, 1'b1, min_r <= total_r, "low-water mark above free count")
  `CHFT_ASSERT_NOW(a_rem_lt_div, state_r == S_DIV, rem_r < div_r, "remainder not below divisor")
  `CHFT_ASSERT_NEXT(a_commit_out, state_r == S_COMMIT && commit_en, out_valid_r,
                    "commit did not load a result")
endmodule
`default_nettype wire
